// ===== hdl/chacc_pkg.sv =====
// ----------------------------------------------------------------------------
// chacc_pkg
// Types and codes shared by the per-channel hit accumulator table.
// ----------------------------------------------------------------------------
package chacc_pkg;

   localparam logic [1:0] MODE_DEPOSIT = 2'd0;
   localparam logic [1:0] MODE_CLEAR   = 2'd1;
   localparam logic [1:0] MODE_READ    = 2'd2;

   localparam logic [2:0] ST_IGNORED = 3'd0;
   localparam logic [2:0] ST_MERGED  = 3'd1;
   localparam logic [2:0] ST_NEW     = 3'd2;
   localparam logic [2:0] ST_DROPPED = 3'd3;
   localparam logic [2:0] ST_READ    = 3'd4;
   localparam logic [2:0] ST_CLEARED = 3'd5;

   typedef struct packed {
      logic [15:0]        channel;
      logic [31:0]        energy;
      logic [31:0]        length;
      logic [39:0]        tstamp;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [30:0]        track;
      logic signed [31:0] particle;
   } entry_type;

endpackage

// ===== hdl/channel_hit_accumulator_table.sv =====
// ----------------------------------------------------------------------------
// channel_hit_accumulator_table
// Per-event table of detector hits, one entry per channel, kept in one RAM.
// ----------------------------------------------------------------------------
// One item is worked on at a time. A deposit searches the entries in use
// linearly through the single RAM read port, one entry per cycle, then
// merges (one read-modify-write) or appends, or drops the item when the
// table is full. A read of an entry in use passes through a read-data
// state; clear, ignored items and reads past the end go straight to the
// result state.
// A new item is accepted as soon as the previous one has been handed to the
// output register, even if that result has not yet been taken. Clear only
// resets the fill count, so no clearing pass runs after reset.
module channel_hit_accumulator_table #(
   parameter int MAX_ENTRIES = 64,
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_mode,
   input  logic [15:0]         req_channel,
   input  logic [5:0]          req_entry_index,
   input  logic [31:0]         req_energy_dep,
   input  logic [31:0]         req_step_length,
   input  logic [39:0]         req_step_time,
   input  logic signed [31:0]  req_pos_x,
   input  logic signed [31:0]  req_pos_y,
   input  logic signed [31:0]  req_pos_z,
   input  logic [30:0]         req_track_number,
   input  logic signed [31:0]  req_particle_code,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [2:0]          rsp_status,
   output logic [CNT_W-1:0]    rsp_entry_count,
   output logic [15:0]         rsp_rd_channel,
   output logic [31:0]         rsp_rd_energy,
   output logic [31:0]         rsp_rd_length,
   output logic [39:0]         rsp_rd_time,
   output logic signed [31:0]  rsp_rd_pos_x,
   output logic signed [31:0]  rsp_rd_pos_y,
   output logic signed [31:0]  rsp_rd_pos_z,
   output logic [30:0]         rsp_rd_track,
   output logic signed [31:0]  rsp_rd_particle
);
   import chacc_pkg::*;

   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int IW = (CNT_W > 6) ? CNT_W : 6;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SEARCH = 3'd1;
   localparam logic [2:0] S_MERGE  = 3'd2;
   localparam logic [2:0] S_RDATA  = 3'd3;
   localparam logic [2:0] S_RESP   = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] used_ff, used_in;
   logic [CNT_W-1:0] ptr_ff, ptr_in;
   logic             pend_ff, pend_in;
   logic [AW-1:0]    rd_addr_ff, rd_addr_in;
   entry_type        req_rec_ff, req_rec_in;
   logic [2:0]       status_ff, status_in;
   entry_type        res_ff, res_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0] rsp_count_ff, rsp_count_in;
   entry_type        rsp_rec_ff, rsp_rec_in;

   entry_type        mem [0:MAX_ENTRIES-1];
   entry_type        mem_q_ff;
   logic             rd_en, wr_en;
   logic [AW-1:0]    rd_addr, wr_addr;
   entry_type        wr_data;

   logic             accept, hit, rsp_load;
   logic [IW-1:0]    idx_ext;
   logic [32:0]      e_sum, l_sum;
   entry_type        merged;

   assign accept  = req_valid && (state_ff == S_IDLE);
   assign idx_ext = IW'(req_entry_index);
   assign hit     = pend_ff && (mem_q_ff.channel == req_rec_ff.channel);
   assign rsp_load = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      e_sum = {1'b0, mem_q_ff.energy} + {1'b0, req_rec_ff.energy};
      l_sum = {1'b0, mem_q_ff.length} + {1'b0, req_rec_ff.length};
      merged = mem_q_ff;
      merged.energy = e_sum[32] ? '1 : e_sum[31:0];
      merged.length = l_sum[32] ? '1 : l_sum[31:0];
      if (req_rec_ff.tstamp < mem_q_ff.tstamp) begin
         merged.tstamp = req_rec_ff.tstamp;
      end
   end

   always_comb begin
      state_in   = state_ff;
      used_in    = used_ff;
      ptr_in     = ptr_ff;
      pend_in    = 1'b0;
      rd_addr_in = rd_addr_ff;
      req_rec_in = req_rec_ff;
      status_in  = status_ff;
      res_in     = res_ff;
      rd_en      = 1'b0;
      rd_addr    = rd_addr_ff;
      wr_en      = 1'b0;
      wr_addr    = rd_addr_ff;
      wr_data    = merged;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_rec_in    = rsp_rec_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_rec_in.channel  = req_channel;
               req_rec_in.energy   = req_energy_dep;
               req_rec_in.length   = req_step_length;
               req_rec_in.tstamp   = req_step_time;
               req_rec_in.pos_x    = req_pos_x;
               req_rec_in.pos_y    = req_pos_y;
               req_rec_in.pos_z    = req_pos_z;
               req_rec_in.track    = req_track_number;
               req_rec_in.particle = req_particle_code;
               res_in   = '0;
               state_in = S_RESP;
               case (req_mode)
                  MODE_CLEAR: begin
                     used_in   = '0;
                     status_in = ST_CLEARED;
                  end
                  MODE_READ: begin
                     status_in = ST_READ;
                     if (idx_ext < IW'(used_ff)) begin
                        rd_en    = 1'b1;
                        rd_addr  = AW'(idx_ext);
                        state_in = S_RDATA;
                     end
                  end
                  MODE_DEPOSIT: begin
                     status_in = ST_IGNORED;
                     if (req_energy_dep != '0) begin
                        ptr_in   = '0;
                        state_in = S_SEARCH;
                     end
                  end
                  default: begin
                     status_in = ST_IGNORED;
                  end
               endcase
            end
         end
         S_SEARCH: begin
            if (hit) begin
               state_in = S_MERGE;
            end else if (ptr_ff < used_ff) begin
               rd_en      = 1'b1;
               rd_addr    = ptr_ff[AW-1:0];
               rd_addr_in = ptr_ff[AW-1:0];
               pend_in    = 1'b1;
               ptr_in     = ptr_ff + 1'b1;
            end else if (!pend_ff) begin
               state_in = S_RESP;
               if (used_ff < CNT_W'(MAX_ENTRIES)) begin
                  wr_en     = 1'b1;
                  wr_addr   = used_ff[AW-1:0];
                  wr_data   = req_rec_ff;
                  used_in   = used_ff + 1'b1;
                  status_in = ST_NEW;
               end else begin
                  status_in = ST_DROPPED;
               end
            end
         end
         S_MERGE: begin
            wr_en     = 1'b1;
            status_in = ST_MERGED;
            state_in  = S_RESP;
         end
         S_RDATA: begin
            res_in   = mem_q_ff;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_load) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_count_in  = used_ff;
               rsp_rec_in    = res_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         mem_q_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff        <= ptr_in;
      rd_addr_ff    <= rd_addr_in;
      req_rec_ff    <= req_rec_in;
      status_ff     <= status_in;
      res_ff        <= res_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_rec_ff    <= rsp_rec_in;
   end

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_rd_channel  = rsp_rec_ff.channel;
   assign rsp_rd_energy   = rsp_rec_ff.energy;
   assign rsp_rd_length   = rsp_rec_ff.length;
   assign rsp_rd_time     = rsp_rec_ff.tstamp;
   assign rsp_rd_pos_x    = rsp_rec_ff.pos_x;
   assign rsp_rd_pos_y    = rsp_rec_ff.pos_y;
   assign rsp_rd_pos_z    = rsp_rec_ff.pos_z;
   assign rsp_rd_track    = rsp_rec_ff.track;
   assign rsp_rd_particle = rsp_rec_ff.particle;

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CNT_W'(MAX_ENTRIES))
      else $error("entry count beyond table size");

   a_used_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && (used_ff != $past(used_ff))
      |-> (used_ff == '0) || (used_ff == $past(used_ff) + 1'b1))
      else $error("entry count moved by other than append or clear");

   a_write_state: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_SEARCH) || (state_ff == S_MERGE))
      else $error("table write outside search or merge");

   a_clear: assert property (@(posedge clock) disable iff (reset)
      accept && (req_mode == MODE_CLEAR) |=> (used_ff == '0))
      else $error("clear did not empty the table");

   a_rd_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != ST_READ) |-> (rsp_rec_ff == '0))
      else $error("read fields nonzero in non-read result");

endmodule
